/* rtl/core/a64_fdec_pkg.sv */
// Shared types and constants of the AArch64 instruction field decoder.
// Holds the instruction class table and the decoded result record.
// No dependencies.
package a64_fdec_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IMM_W  = 26;
  localparam int unsigned REG_W  = 6;
  localparam int unsigned SLOTS  = 4;

  localparam logic [REG_W-1:0] REG_NONE = {REG_W{1'b1}};

  typedef enum logic [1:0] {
    CLS_INT  = 2'd0,
    CLS_LDST = 2'd1,
    CLS_BR   = 2'd2,
    CLS_FP   = 2'd3
  } cls_t;

  typedef struct packed {
    logic [WORD_W-1:0]            word;
    logic [SLOTS-1:0][IMM_W-1:0]  imm;
    logic [SLOTS-1:0][REG_W-1:0]  rg;
    logic                         status;
  } dec_res_t;

  function automatic cls_t class_of(input logic [3:0] op);
    cls_t c;
    case (op)
      4'h0, 4'h1, 4'h2, 4'h3, 4'ha, 4'hb: c = CLS_INT;
      4'h4, 4'h5, 4'h6, 4'h7:             c = CLS_BR;
      4'h8, 4'h9, 4'hc, 4'hd:             c = CLS_LDST;
      default:                            c = CLS_FP;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/a64_fdec_decode.sv */
// Combinational field extraction for one AArch64 instruction word.
// Depends on a64_fdec_pkg for the class table and result record.
module a64_fdec_decode
  import a64_fdec_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  output dec_res_t          res
);

  logic [WORD_W-1:0]           w;
  logic [SLOTS-1:0][IMM_W-1:0] imm;
  logic [SLOTS-1:0][REG_W-1:0] rg;
  logic                        status;

  assign w = word;

  always_comb begin
    imm    = '0;
    rg     = {SLOTS{REG_NONE}};
    status = 1'b0;
    case (class_of(w[27:24]))
      CLS_INT: begin
        imm[0] = IMM_W'(w[31]);
        if (w[27]) begin
          if (w[28]) begin
            case (w[24:22])
              3'd0: begin
                rg[0] = REG_W'(w[20:16]);
                rg[1] = REG_W'(w[9:5]);
                rg[2] = REG_W'(w[4:0]);
              end
              3'd1: begin
                if (w[11]) begin
                  imm[1] = IMM_W'(w[20:16]);
                  imm[2] = IMM_W'(w[15:12]);
                  imm[3] = IMM_W'(w[3:0]);
                  rg[0]  = REG_W'(w[9:5]);
                end else begin
                  imm[1] = IMM_W'(w[15:12]);
                  imm[2] = IMM_W'(w[3:0]);
                  rg[0]  = REG_W'(w[20:16]);
                  rg[1]  = REG_W'(w[9:5]);
                end
              end
              3'd2: begin
                imm[1] = IMM_W'(w[15:12]);
                rg[0]  = REG_W'(w[20:16]);
                rg[1]  = REG_W'(w[9:5]);
                rg[2]  = REG_W'(w[4:0]);
              end
              3'd3: begin
                if (w[30]) begin
                  rg[0] = REG_W'(w[9:5]);
                  rg[1] = REG_W'(w[4:0]);
                end else begin
                  rg[0] = REG_W'(w[20:16]);
                  rg[1] = REG_W'(w[9:5]);
                  rg[2] = REG_W'(w[4:0]);
                end
              end
              default: begin
                rg[0] = REG_W'(w[20:16]);
                rg[1] = REG_W'(w[14:10]);
                rg[2] = REG_W'(w[9:5]);
                rg[3] = REG_W'(w[4:0]);
              end
            endcase
          end else begin
            if (w[24] && w[21]) begin
              imm[1] = IMM_W'(w[15:13]);
              imm[2] = IMM_W'(w[12:10]);
            end else begin
              imm[1] = IMM_W'(w[23:22]);
              imm[2] = IMM_W'(w[15:10]);
            end
            rg[0] = REG_W'(w[20:16]);
            rg[1] = REG_W'(w[9:5]);
            rg[2] = REG_W'(w[4:0]);
          end
        end else begin
          case (w[25:23])
            3'd0, 3'd1: begin
              imm[0] = IMM_W'(w[30:29]);
              imm[1] = IMM_W'(w[23:5]);
              rg[0]  = REG_W'(w[4:0]);
            end
            3'd2, 3'd3: begin
              imm[1] = IMM_W'(w[23:22]);
              imm[2] = IMM_W'(w[21:10]);
              rg[0]  = REG_W'(w[9:5]);
              rg[1]  = REG_W'(w[4:0]);
            end
            3'd4, 3'd6: begin
              imm[1] = IMM_W'(w[21:16]);
              imm[2] = IMM_W'(w[15:10]);
              rg[0]  = REG_W'(w[9:5]);
              rg[1]  = REG_W'(w[4:0]);
            end
            3'd5: begin
              imm[1] = IMM_W'(w[22:21]);
              imm[2] = IMM_W'(w[20:5]);
              rg[0]  = REG_W'(w[4:0]);
            end
            default: begin
              imm[1] = IMM_W'(w[15:10]);
              rg[0]  = REG_W'(w[20:16]);
              rg[1]  = REG_W'(w[9:5]);
              rg[2]  = REG_W'(w[4:0]);
            end
          endcase
        end
      end
      CLS_LDST: begin
        case (w[29:28])
          2'd0: begin
            if (!w[26]) begin
              rg[0] = REG_W'(w[20:16]);
              rg[1] = REG_W'(w[14:10]);
              rg[2] = REG_W'(w[9:5]);
              rg[3] = REG_W'(w[4:0]);
            end
          end
          2'd1: begin
            rg[0]  = REG_W'(w[4:0]);
            imm[0] = IMM_W'($signed(w[23:5]));
          end
          2'd2: begin
            imm[0] = IMM_W'(w[21:15]);
            rg[0]  = REG_W'(w[14:10]);
            rg[1]  = REG_W'(w[9:5]);
            rg[2]  = REG_W'(w[4:0]);
          end
          default: begin
            rg[0] = REG_W'(w[9:5]);
            rg[1] = REG_W'(w[4:0]);
            if (w[24]) begin
              imm[0] = IMM_W'(w[21:10]);
            end else if (w[10]) begin
              imm[0] = IMM_W'($signed(w[20:12]));
            end else if (w[11] && w[21]) begin
              imm[0] = IMM_W'(w[15:13]);
              imm[1] = IMM_W'(w[12]);
              rg[0]  = REG_W'(w[20:16]);
              rg[1]  = REG_W'(w[9:5]);
              rg[2]  = REG_W'(w[4:0]);
            end else begin
              imm[0] = IMM_W'(w[20:12]);
            end
          end
        endcase
      end
      CLS_BR: begin
        case (w[31:29])
          3'd0, 3'd4: begin
            imm[0] = IMM_W'($signed(w[25:0]));
          end
          3'd1, 3'd5: begin
            rg[0]  = REG_W'(w[4:0]);
            imm[0] = IMM_W'(w[31]);
            if (w[25]) begin
              imm[1] = IMM_W'(w[23:19]);
              imm[2] = IMM_W'($signed(w[18:5]));
            end else begin
              imm[1] = IMM_W'(w[23:5]);
            end
          end
          3'd2: begin
            imm[0] = IMM_W'(w[23:5]);
            imm[1] = IMM_W'(w[3:0]);
          end
          3'd6: begin
            case (w[25:24])
              2'd0:    imm[0] = IMM_W'(w[20:5]);
              2'd1:    rg[0]  = REG_W'(w[4:0]);
              default: rg[0]  = REG_W'(w[9:5]);
            endcase
          end
          default: begin
          end
        endcase
      end
      default: begin
        status = 1'b1;
      end
    endcase
  end

  always_comb begin
    res.word   = w;
    res.imm    = imm;
    res.rg     = rg;
    res.status = status;
  end

endmodule

/* rtl/core/arm64_instruction_field_decoder.sv */
// AArch64 instruction field decoder, top level.
// Registered path from input transfer to result transfer: input register, then result register.
// Throughput: one word per cycle; input stalls only while both registers are full and
// out_tready is low.
// Reset: rst_n synchronous, active low; clears both valid flags, payload is not reset.
// Depends on a64_fdec_pkg and a64_fdec_decode.
module arm64_instruction_field_decoder
  import a64_fdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // code_word[31:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // word_echo[31:0], imm_a..imm_d[26 each], reg_a..reg_d[6 each]
  output logic         out_tuser   // status
);

  logic              in_vld_r;
  logic [WORD_W-1:0] in_word_r;
  logic              out_vld_r;
  dec_res_t          out_res_r;
  dec_res_t          dec_res;
  logic              out_adv;
  logic              in_adv;

  a64_fdec_decode u_decode (
    .word (in_word_r),
    .res  (dec_res)
  );

  assign out_adv   = !out_vld_r || out_tready;
  assign in_adv    = !in_vld_r || out_adv;
  assign in_tready = in_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_r <= in_tvalid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
    // hold payload unless its stage advances
    if (in_adv && in_tvalid) begin
      in_word_r <= in_tdata;
    end
    if (out_adv && in_vld_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.status;

  always_comb begin
    out_tdata[31:0]    = out_res_r.word;
    out_tdata[57:32]   = out_res_r.imm[0];
    out_tdata[83:58]   = out_res_r.imm[1];
    out_tdata[109:84]  = out_res_r.imm[2];
    out_tdata[135:110] = out_res_r.imm[3];
    out_tdata[141:136] = out_res_r.rg[0];
    out_tdata[147:142] = out_res_r.rg[1];
    out_tdata[153:148] = out_res_r.rg[2];
    out_tdata[159:154] = out_res_r.rg[3];
  end

endmodule

/* verif/arm64_instruction_field_decoder_tb.sv */
// Self-checking testbench for arm64_instruction_field_decoder: streams instruction words,
// predicts every slot of the decoded result and compares each output transfer field by field.
// Depends on a64_fdec_pkg and the decoder RTL.
`timescale 1ns / 100ps

module arm64_instruction_field_decoder_tb;
  import a64_fdec_pkg::*;

  localparam int N_RANDOM     = 750;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 100;
  localparam int DRAIN_AT     = 500;
  localparam int QUIET_TAIL   = 80;

  typedef struct packed {
    logic [WORD_W-1:0]           word;
    logic [SLOTS-1:0][IMM_W-1:0] imm;
    logic [SLOTS-1:0][REG_W-1:0] rg;
    logic                        status;
  } decoded_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;  // word_echo[31:0], imm_a..imm_d[26 each], reg_a..reg_d[6 each]
  logic         out_tuser;  // status

  logic [31:0] pending_words[$];
  decoded_t    expected_results[$];
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_fail = 0;
  int          send_gap = 0;
  int          recv_hold = 0;
  bit          drain_done = 1'b0;
  bit          long_hold_done = 1'b0;

  string imm_names[SLOTS] = '{"imm_a", "imm_b", "imm_c", "imm_d"};
  string reg_names[SLOTS] = '{"reg_a", "reg_b", "reg_c", "reg_d"};

  arm64_instruction_field_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t   r;
    cls_t       cls;
    logic [5:0] f0, f5, f10, f16;
    f0  = {1'b0, w[4:0]};
    f5  = {1'b0, w[9:5]};
    f10 = {1'b0, w[14:10]};
    f16 = {1'b0, w[20:16]};
    r.word   = w;
    r.imm    = '0;
    r.rg     = {SLOTS{REG_NONE}};
    r.status = 1'b0;
    case (w[27:24])
      4'h0, 4'h1, 4'h2, 4'h3, 4'ha, 4'hb: cls = CLS_INT;
      4'h4, 4'h5, 4'h6, 4'h7:             cls = CLS_BR;
      4'h8, 4'h9, 4'hc, 4'hd:             cls = CLS_LDST;
      default:                            cls = CLS_FP;
    endcase
    case (cls)
      CLS_INT: begin
        r.imm[0] = IMM_W'(w[31]);
        if (w[27]) begin
          if (w[28]) begin
            case (w[24:22])
              3'd0: {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
              3'd1: begin
                if (w[11]) begin
                  r.imm[1] = IMM_W'(w[20:16]);
                  r.imm[2] = IMM_W'(w[15:12]);
                  r.imm[3] = IMM_W'(w[3:0]);
                  r.rg[0]  = f5;
                end else begin
                  r.imm[1] = IMM_W'(w[15:12]);
                  r.imm[2] = IMM_W'(w[3:0]);
                  r.rg[0]  = f16;
                  r.rg[1]  = f5;
                end
              end
              3'd2: begin
                r.imm[1] = IMM_W'(w[15:12]);
                {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
              end
              3'd3: begin
                if (w[30]) begin
                  r.rg[0] = f5;
                  r.rg[1] = f0;
                end else begin
                  {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
                end
              end
              default: {r.rg[3], r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f10, f16};
            endcase
          end else begin
            if (w[24] && w[21]) begin
              r.imm[1] = IMM_W'(w[15:13]);
              r.imm[2] = IMM_W'(w[12:10]);
            end else begin
              r.imm[1] = IMM_W'(w[23:22]);
              r.imm[2] = IMM_W'(w[15:10]);
            end
            {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
          end
        end else begin
          case (w[25:23])
            3'd0, 3'd1: begin
              r.imm[0] = IMM_W'(w[30:29]);
              r.imm[1] = IMM_W'(w[23:5]);
              r.rg[0]  = f0;
            end
            3'd2, 3'd3: begin
              r.imm[1] = IMM_W'(w[23:22]);
              r.imm[2] = IMM_W'(w[21:10]);
              r.rg[0]  = f5;
              r.rg[1]  = f0;
            end
            3'd4, 3'd6: begin
              r.imm[1] = IMM_W'(w[21:16]);
              r.imm[2] = IMM_W'(w[15:10]);
              r.rg[0]  = f5;
              r.rg[1]  = f0;
            end
            3'd5: begin
              r.imm[1] = IMM_W'(w[22:21]);
              r.imm[2] = IMM_W'(w[20:5]);
              r.rg[0]  = f0;
            end
            default: begin
              r.imm[1] = IMM_W'(w[15:10]);
              {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
            end
          endcase
        end
      end
      CLS_LDST: begin
        case (w[29:28])
          2'd0: begin
            if (!w[26]) {r.rg[3], r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f10, f16};
          end
          2'd1: begin
            r.rg[0]  = f0;
            r.imm[0] = {{7{w[23]}}, w[23:5]};
          end
          2'd2: begin
            r.imm[0] = IMM_W'(w[21:15]);
            {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f10};
          end
          default: begin
            r.rg[0] = f5;
            r.rg[1] = f0;
            if (w[24]) begin
              r.imm[0] = IMM_W'(w[21:10]);
            end else if (w[10]) begin
              r.imm[0] = {{17{w[20]}}, w[20:12]};
            end else if (w[11] && w[21]) begin
              r.imm[0] = IMM_W'(w[15:13]);
              r.imm[1] = IMM_W'(w[12]);
              {r.rg[2], r.rg[1], r.rg[0]} = {f0, f5, f16};
            end else begin
              r.imm[0] = IMM_W'(w[20:12]);
            end
          end
        endcase
      end
      CLS_BR: begin
        case (w[31:29])
          3'd0, 3'd4: r.imm[0] = w[25:0];
          3'd1, 3'd5: begin
            r.rg[0]  = f0;
            r.imm[0] = IMM_W'(w[31]);
            if (w[25]) begin
              r.imm[1] = IMM_W'(w[23:19]);
              r.imm[2] = {{12{w[18]}}, w[18:5]};
            end else begin
              r.imm[1] = IMM_W'(w[23:5]);
            end
          end
          3'd2: begin
            r.imm[0] = IMM_W'(w[23:5]);
            r.imm[1] = IMM_W'(w[3:0]);
          end
          3'd6: begin
            case (w[25:24])
              2'd0:    r.imm[0] = IMM_W'(w[20:5]);
              2'd1:    r.rg[0]  = f0;
              default: r.rg[0]  = f5;
            endcase
          end
          default: ;
        endcase
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  // fill the bits outside mask at random
  task automatic queue_word(input logic [31:0] mask, input logic [31:0] value);
    pending_words.push_back(($urandom & ~mask) | (value & mask));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(decode_word(in_tdata));
        void'(pending_words.pop_front());
        n_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered word
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (n_sent == DRAIN_AT && !drain_done) begin
        in_tvalid <= 1'b0;
        if (expected_results.size() == 0) drain_done = 1'b1;
      end else if (pending_words.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_words[0];
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: word %08h", out_tdata[31:0]);
          n_fail++;
        end else begin
          decoded_t want;
          want = expected_results.pop_front();
          if (out_tdata[31:0] !== want.word) begin
            $error("word_echo: expected %08h, got %08h", want.word, out_tdata[31:0]);
            n_fail++;
          end
          for (int i = 0; i < SLOTS; i++) begin
            if (out_tdata[32 + IMM_W*i +: IMM_W] !== want.imm[i]) begin
              $error("%s: expected %0d, got %0d (word %08h)", imm_names[i],
                     $signed(want.imm[i]), $signed(out_tdata[32 + IMM_W*i +: IMM_W]),
                     want.word);
              n_fail++;
            end
            if (out_tdata[136 + REG_W*i +: REG_W] !== want.rg[i]) begin
              $error("%s: expected %0d, got %0d (word %08h)", reg_names[i],
                     $signed(want.rg[i]), $signed(out_tdata[136 + REG_W*i +: REG_W]),
                     want.word);
              n_fail++;
            end
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0b, got %0b (word %08h)", want.status, out_tuser,
                   want.word);
            n_fail++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else if (n_checked == LONG_HOLD_AT && !long_hold_done) begin
        long_hold_done = 1'b1;
        recv_hold = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        recv_hold = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick;
    // extremes and the floating point group
    queue_word('1, 32'h0000_0000);
    queue_word('1, 32'hFFFF_FFFF);
    queue_word(32'h0F00_0000, 32'h0E00_0000);
    // conditional compare, immediate and register forms
    queue_word(32'h1FC0_0800, 32'h1A40_0800);
    queue_word(32'h1FC0_0800, 32'h1A40_0000);
    // negative offsets: branch, test-and-branch, load literal, pre/post-indexed
    queue_word(32'hEE00_0000, 32'h0600_0000);
    queue_word(32'h6E04_0000, 32'h2604_0000);
    queue_word(32'h3A80_0000, 32'h1880_0000);
    queue_word(32'h3B10_0C00, 32'h3810_0400);
    queue_word(32'h3B10_0C00, 32'h3810_0C00);
    // vector load/store, register offset, branch groups with no sub-decoder
    queue_word(32'h3E00_0000, 32'h0C00_0000);
    queue_word(32'h3B20_0C00, 32'h3820_0800);
    queue_word(32'hEC00_0000, 32'h6400_0000);
    queue_word(32'hEC00_0000, 32'hE400_0000);
    for (int k = 0; k < 8; k++) queue_word(32'h0B80_0000, k << 23);

    for (int n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: queue_word('0, '0);
        1: queue_word(32'h0800_0000, 32'h0000_0000);
        2: queue_word(32'h0E00_0000, 32'h0A00_0000);
        3: queue_word(32'h0A00_0000, 32'h0800_0000);
        4: queue_word(32'h0C00_0000, 32'h0400_0000);
        default: queue_word(32'h0E00_0000, 32'h0E00_0000);
      endcase
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (n_fail == 0) begin
      $display("arm64_instruction_field_decoder_tb OK");
    end else begin
      $display("arm64_instruction_field_decoder_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("arm64_instruction_field_decoder_tb NOT OK");
    $finish;
  end

endmodule
